// ===== rtl/sbl_pkg.sv =====
`default_nettype none

package sbl_pkg;

  // status codes carried in a result beat
  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam int ELEM_W  = 8;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic              kind;
    logic [ELEM_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ELEM_W-1:0]  element;
    logic               element_valid;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_DEL,
    ST_LIST0,
    ST_LIST
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    WA_ZERO,
    WA_ABOVE,
    WA_BELOW
  } wa_sel_t;

  typedef enum logic {
    WD_VALUE,
    WD_DATA
  } wd_sel_t;

  typedef enum logic [1:0] {
    OCC_HOLD,
    OCC_INC,
    OCC_DEC
  } occ_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_SINGLE,
    EMIT_ELEM
  } emit_t;

  typedef struct packed {
    logic       latch_in;
    idx_op_t    idx_op;
    logic       wr_en;
    wa_sel_t    wa_sel;
    wd_sel_t    wd_sel;
    occ_op_t    occ_op;
    logic       found_clr;
    logic       found_set;
    emit_t      emit;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic occ_full;
    logic occ_zero;
    logic idx_zero;
    logic at_end;
    logic rd_gt;
    logic rd_eq;
    logic found;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbl_ram.sv =====
`default_nettype none

module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/sbl_ctrl.sv =====
`default_nettype none

module sbl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          kind,
  input  wire sbl_pkg::sts_t sts,
  output logic               busy,
  output sbl_pkg::cmd_t      cmd
);

  sbl_pkg::state_t state_r, state_nxt;
  logic            found_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != sbl_pkg::ST_IDLE);
  assign found_now = sts.found | sts.rd_eq;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.idx_op    = sbl_pkg::IDX_HOLD;
    cmd.wa_sel    = sbl_pkg::WA_ZERO;
    cmd.wd_sel    = sbl_pkg::WD_VALUE;
    cmd.occ_op    = sbl_pkg::OCC_HOLD;
    cmd.emit      = sbl_pkg::EMIT_NONE;
    cmd.status    = sbl_pkg::STATUS_DONE;
    case (state_r)
      sbl_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          if (kind == sbl_pkg::KIND_INSERT) begin
            if (sts.occ_full) begin
              cmd.emit   = sbl_pkg::EMIT_SINGLE;
              cmd.status = sbl_pkg::STATUS_FULL;
            end else if (sts.occ_zero) begin
              state_nxt = sbl_pkg::ST_PUT;
            end else begin
              cmd.idx_op = sbl_pkg::IDX_TOP;
              state_nxt  = sbl_pkg::ST_INS;
            end
          end else begin
            if (sts.occ_zero) begin
              cmd.emit   = sbl_pkg::EMIT_SINGLE;
              cmd.status = sbl_pkg::STATUS_MISS;
            end else begin
              cmd.idx_op    = sbl_pkg::IDX_ZERO;
              cmd.found_clr = 1'b1;
              state_nxt     = sbl_pkg::ST_DEL;
            end
          end
        end
      end
      // walk down from the top, moving larger entries up one slot
      sbl_pkg::ST_INS: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = sbl_pkg::WA_ABOVE;
        if (sts.rd_gt) begin
          cmd.wd_sel = sbl_pkg::WD_DATA;
          if (sts.idx_zero) begin
            state_nxt = sbl_pkg::ST_PUT;
          end else begin
            cmd.idx_op = sbl_pkg::IDX_DEC;
          end
        end else begin
          cmd.wd_sel = sbl_pkg::WD_VALUE;
          cmd.occ_op = sbl_pkg::OCC_INC;
          state_nxt  = sbl_pkg::ST_LIST0;
        end
      end
      sbl_pkg::ST_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = sbl_pkg::WA_ZERO;
        cmd.wd_sel = sbl_pkg::WD_VALUE;
        cmd.occ_op = sbl_pkg::OCC_INC;
        state_nxt  = sbl_pkg::ST_LIST0;
      end
      // walk up; after the match every entry moves down one slot
      sbl_pkg::ST_DEL: begin
        cmd.wr_en     = sts.found;
        cmd.wa_sel    = sbl_pkg::WA_BELOW;
        cmd.wd_sel    = sbl_pkg::WD_DATA;
        cmd.found_set = sts.rd_eq;
        if (sts.at_end) begin
          if (found_now) begin
            cmd.occ_op = sbl_pkg::OCC_DEC;
            state_nxt  = sbl_pkg::ST_LIST0;
          end else begin
            cmd.emit   = sbl_pkg::EMIT_SINGLE;
            cmd.status = sbl_pkg::STATUS_MISS;
            state_nxt  = sbl_pkg::ST_IDLE;
          end
        end else begin
          cmd.idx_op = sbl_pkg::IDX_INC;
        end
      end
      sbl_pkg::ST_LIST0: begin
        if (sts.occ_zero) begin
          cmd.emit   = sbl_pkg::EMIT_SINGLE;
          cmd.status = sbl_pkg::STATUS_DONE;
          state_nxt  = sbl_pkg::ST_IDLE;
        end else begin
          cmd.idx_op = sbl_pkg::IDX_ZERO;
          state_nxt  = sbl_pkg::ST_LIST;
        end
      end
      sbl_pkg::ST_LIST: begin
        cmd.emit   = sbl_pkg::EMIT_ELEM;
        cmd.status = sbl_pkg::STATUS_DONE;
        if (sts.at_end) begin
          state_nxt = sbl_pkg::ST_IDLE;
        end else begin
          cmd.idx_op = sbl_pkg::IDX_INC;
        end
      end
      default: begin
        state_nxt = sbl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sbl_dp.sv =====
`default_nettype none

module sbl_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sbl_pkg::in_beat_t in_beat,
  input  wire sbl_pkg::cmd_t     cmd,
  output sbl_pkg::sts_t          sts,
  output logic                   out_strobe,
  output sbl_pkg::out_beat_t     out_beat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [sbl_pkg::ELEM_W-1:0] val_r;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              occ_r, occ_nxt;
  logic                       found_r, found_nxt;
  logic                       strobe_r;
  sbl_pkg::out_beat_t         beat_r, beat_nxt;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [sbl_pkg::ELEM_W-1:0] wr_data;
  logic [sbl_pkg::ELEM_W-1:0] rd_data;
  logic [31:0]                occ_wide;

  sbl_ram #(
    .WIDTH (sbl_pkg::ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx_nxt),
    .rdata (rd_data)
  );

  // read data always belongs to idx_r: the RAM is read at idx_nxt each cycle
  always_comb begin
    case (cmd.idx_op)
      sbl_pkg::IDX_TOP:  idx_nxt = AW'(occ_r - CW'(1));
      sbl_pkg::IDX_ZERO: idx_nxt = '0;
      sbl_pkg::IDX_INC:  idx_nxt = idx_r + AW'(1);
      sbl_pkg::IDX_DEC:  idx_nxt = idx_r - AW'(1);
      default:           idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      sbl_pkg::WA_ABOVE: wr_addr = idx_r + AW'(1);
      sbl_pkg::WA_BELOW: wr_addr = idx_r - AW'(1);
      default:           wr_addr = '0;
    endcase
  end

  assign wr_en   = cmd.wr_en;
  assign wr_data = (cmd.wd_sel == sbl_pkg::WD_DATA) ? rd_data : val_r;

  always_comb begin
    case (cmd.occ_op)
      sbl_pkg::OCC_INC: occ_nxt = occ_r + CW'(1);
      sbl_pkg::OCC_DEC: occ_nxt = occ_r - CW'(1);
      default:          occ_nxt = occ_r;
    endcase
  end

  always_comb begin
    found_nxt = found_r;
    if (cmd.found_clr) begin
      found_nxt = 1'b0;
    end else if (cmd.found_set) begin
      found_nxt = 1'b1;
    end
  end

  assign occ_wide = 32'(occ_r);

  always_comb begin
    beat_nxt             = beat_r;
    beat_nxt.status      = cmd.status;
    beat_nxt.entry_count = occ_wide[sbl_pkg::COUNT_W-1:0];
    case (cmd.emit)
      sbl_pkg::EMIT_ELEM: begin
        beat_nxt.element       = rd_data;
        beat_nxt.element_valid = 1'b1;
        beat_nxt.last          = sts.at_end;
      end
      default: begin
        beat_nxt.element       = '0;
        beat_nxt.element_valid = 1'b0;
        beat_nxt.last          = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      occ_r    <= occ_nxt;
      idx_r    <= idx_nxt;
      found_r  <= found_nxt;
      strobe_r <= (cmd.emit != sbl_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      val_r <= in_beat.value;
    end
    if (cmd.emit != sbl_pkg::EMIT_NONE) begin
      beat_r <= beat_nxt;
    end
  end

  assign sts.occ_full = (occ_r == CW'(DEPTH));
  assign sts.occ_zero = (occ_r == '0);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.at_end   = ((CW'(idx_r) + CW'(1)) == occ_r);
  assign sts.rd_gt    = (rd_data > val_r);
  assign sts.rd_eq    = (rd_data == val_r);
  assign sts.found    = found_r;

  assign out_strobe = strobe_r;
  assign out_beat   = beat_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) <= occ_r))
    else $error("write outside the held list");

  a_elem_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == sbl_pkg::EMIT_ELEM) |-> (occ_r != '0))
    else $error("element emitted from empty list");

endmodule

`default_nettype wire

// ===== rtl/sorted_byte_list.sv =====
// Channel  | Ports                        | Handshake
// ---------+------------------------------+-----------------------------------------
// input    | start, busy, in_beat         | beat taken when start && !busy
// result   | out_strobe, out_beat         | beat valid for the one strobe cycle
//
// Steps: busy after the accepting edge, N entries held: an insert landing in
// slot p walks down from the top, ST_LIST0 starts the read, then N + 1 beats
// stream. A remove walks all N entries, on a hit and on a miss alike; the RAM
// reads one entry per cycle. Full insert and remove-from-empty are answered
// from idle with a single beat. Reset: synchronous, active low; the list comes
// up empty, RAM is not cleared. The receiver cannot stall.
`default_nettype none

module sorted_byte_list #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sbl_pkg::in_beat_t  in_beat,
  output logic                    out_strobe,
  output sbl_pkg::out_beat_t      out_beat
);

  sbl_pkg::cmd_t cmd;
  sbl_pkg::sts_t sts;

  // sequencer: decides each step of the insert, remove and list walks
  sbl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_beat.kind),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // entry RAM, walk index, occupancy and the registered result beat
  sbl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_beat    (in_beat),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

  // a result never shows up without an accepted beat or a walk in progress
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start)))
    else $error("result beat without work");

  // an empty result beat always closes its operation
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_beat.element_valid) |-> out_beat.last)
    else $error("empty beat not marked last");

  // refused operations carry no element
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_beat.status != sbl_pkg::STATUS_DONE))
      |-> !out_beat.element_valid)
    else $error("element on a failed operation");

endmodule

`default_nettype wire

// ===== test/tb_sorted_byte_list.sv =====
`default_nettype none

module tb_sorted_byte_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = 16;
  localparam int ELEM_W  = sbl_pkg::ELEM_W;
  localparam int COUNT_W = sbl_pkg::COUNT_W;

  // One row of the directed plan. Rows with fixed set carry a typed-in
  // single beat; all other rows are checked against the list predictor.
  typedef struct packed {
    sbl_pkg::in_beat_t  beat;
    logic               fixed;
    sbl_pkg::out_beat_t result;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  sbl_pkg::in_beat_t  in_beat;
  logic               out_strobe;
  sbl_pkg::out_beat_t out_beat;

  // Shadow copy of the list: held[0 .. held_count-1], ascending.
  logic [ELEM_W-1:0] held [DEPTH];
  int                held_count;

  // Beats the shadow list produces for one operation, then the queue of
  // beats still owed by the block, oldest first.
  sbl_pkg::out_beat_t streamed [DEPTH];
  sbl_pkg::out_beat_t expected_beats [$];

  plan_row_t plan [$];
  int        errors;
  int        burst_left;

  sorted_byte_list #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_beat    (in_beat),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far past the slowest legal run (~120 items, including the
  // longest sender gaps).
  initial begin
    #2ms;
    $display("tb_sorted_byte_list: FAIL");
    $finish;
  end

  // Single beat with no element: miss, full, or the list ran empty.
  function automatic sbl_pkg::out_beat_t single_beat(logic [1:0] status, int count);
    sbl_pkg::out_beat_t r;
    r.status        = status;
    r.element       = '0;
    r.element_valid = 1'b0;
    r.entry_count   = COUNT_W'(count);
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t free_row(logic kind, logic [ELEM_W-1:0] value);
    plan_row_t r;
    r.beat.kind  = kind;
    r.beat.value = value;
    r.fixed      = 1'b0;
    r.result     = '0;
    return r;
  endfunction

  function automatic plan_row_t fixed_row(logic kind, logic [ELEM_W-1:0] value,
                                          logic [1:0] status, int count);
    plan_row_t r;
    r = free_row(kind, value);
    r.fixed  = 1'b1;
    r.result = single_beat(status, count);
    return r;
  endfunction

  // Apply one operation to the shadow list and fill streamed[] with the
  // beats it should cause. n is the number of beats.
  task automatic step_list(input sbl_pkg::in_beat_t b, output int n);
    int pos;
    int j;
    n   = 0;
    pos = 0;
    if (b.kind == sbl_pkg::KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        // full: refused, nothing moves
        streamed[0] = single_beat(sbl_pkg::STATUS_FULL, held_count);
        n = 1;
      end else begin
        // new value lands after every smaller entry
        while (pos < held_count && held[pos] < b.value) pos++;
        for (j = held_count; j > pos; j--) held[j] = held[j-1];
        held[pos] = b.value;
        held_count++;
      end
    end else begin
      while (pos < held_count && held[pos] != b.value) pos++;
      if (pos >= held_count) begin
        streamed[0] = single_beat(sbl_pkg::STATUS_MISS, held_count);
        n = 1;
      end else begin
        // first equal entry goes, the rest close up
        for (j = pos; j + 1 < held_count; j++) held[j] = held[j+1];
        held_count--;
      end
    end
    if (n == 0) begin
      if (held_count == 0) begin
        streamed[0] = single_beat(sbl_pkg::STATUS_DONE, 0);
        n = 1;
      end else begin
        for (j = 0; j < held_count; j++) begin
          streamed[j].status        = sbl_pkg::STATUS_DONE;
          streamed[j].element       = held[j];
          streamed[j].element_valid = 1'b1;
          streamed[j].entry_count   = COUNT_W'(held_count);
          streamed[j].last          = (j + 1 == held_count);
        end
        n = held_count;
      end
    end
  endtask

  // Sender idle time: mostly none or short, now and then long, with
  // occasional back-to-back bursts.
  task automatic sender_gap();
    int gap;
    int r;
    r = $urandom_range(99, 0);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 6) begin
      burst_left = $urandom_range(12, 4);
      gap = 0;
    end else if (r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(3, 1);
    else if (r < 97) gap = $urandom_range(10, 4);
    else gap = $urandom_range(60, 20);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Present one beat from the falling edge and hold it until the block
  // takes it (start && !busy at a rising edge), then log what it owes.
  task automatic send_beat(input sbl_pkg::in_beat_t b, input logic fixed,
                           input sbl_pkg::out_beat_t result);
    int n;
    @(negedge clk);
    start   <= 1'b1;
    in_beat <= b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    step_list(b, n);
    if (fixed) expected_beats.push_back(result);
    else for (int i = 0; i < n; i++) expected_beats.push_back(streamed[i]);
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: the receiver cannot stall, so every strobe is a beat.
  always @(posedge clk) begin
    sbl_pkg::out_beat_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_beat);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status",        want.status,        out_beat.status);
        check_field("element",       want.element,       out_beat.element);
        check_field("element_valid", want.element_valid, out_beat.element_valid);
        check_field("entry_count",   want.entry_count,   out_beat.entry_count);
        check_field("last",          want.last,          out_beat.last);
      end
    end
  end

  initial begin
    sbl_pkg::in_beat_t  b;
    sbl_pkg::out_beat_t none;
    logic               filling;
    logic               want_insert;

    start      = 1'b0;
    in_beat    = '0;
    rst_n      = 1'b0;
    errors     = 0;
    held_count = 0;
    burst_left = 0;
    none       = '0;
    for (int i = 0; i < DEPTH; i++) held[i] = '0;

    // Directed plan: empty list, extremes, equal values, miss, full.
    plan.push_back(fixed_row(sbl_pkg::KIND_REMOVE, 8'h00, sbl_pkg::STATUS_MISS, 0));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hFF));
    plan.push_back(fixed_row(sbl_pkg::KIND_REMOVE, 8'hFF, sbl_pkg::STATUS_DONE, 0));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h00));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hFF));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h80));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h80));          // equal value
    plan.push_back(fixed_row(sbl_pkg::KIND_REMOVE, 8'h07, sbl_pkg::STATUS_MISS, 4));
    plan.push_back(free_row(sbl_pkg::KIND_REMOVE, 8'h80));          // first of equals
    // fill up from three entries to DEPTH, bits of value both ways
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h01));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hFE));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h7F));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h80));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h55));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hAA));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h0F));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hF0));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h33));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hCC));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h00));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'hFF));
    plan.push_back(free_row(sbl_pkg::KIND_INSERT, 8'h80));
    plan.push_back(fixed_row(sbl_pkg::KIND_INSERT, 8'h42, sbl_pkg::STATUS_FULL, DEPTH));
    plan.push_back(free_row(sbl_pkg::KIND_REMOVE, 8'hFF));          // top entry
    plan.push_back(free_row(sbl_pkg::KIND_REMOVE, 8'h00));          // bottom entry

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (plan[i]) begin
      sender_gap();
      send_beat(plan[i].beat, plan[i].fixed, plan[i].result);
    end

    // Let the block run dry once before the random part.
    @(negedge clk) start <= 1'b0;
    wait_drained();

    // Random part: swing between filling and draining so that both the
    // full and the empty ends come up; removes mostly hit held values.
    filling = 1'b0;
    for (int k = 0; k < 95; k++) begin
      if (k == 48) begin
        @(negedge clk) start <= 1'b0;
        wait_drained();
      end
      if (held_count == DEPTH && $urandom_range(2, 0) == 0) filling = 1'b0;
      if (held_count == 0 && $urandom_range(1, 0) == 0) filling = 1'b1;
      if ($urandom_range(29, 0) == 0) filling = !filling;
      want_insert = filling ? ($urandom_range(3, 0) != 0) : ($urandom_range(3, 0) == 0);
      b.kind = want_insert ? sbl_pkg::KIND_INSERT : sbl_pkg::KIND_REMOVE;
      if (!want_insert && held_count > 0 && $urandom_range(9, 0) < 7) begin
        b.value = held[$urandom_range(held_count - 1, 0)];
      end else begin
        case ($urandom_range(7, 0))
          0: b.value = 8'h00;
          1: b.value = 8'hFF;
          default: b.value = ELEM_W'($urandom_range(255, 0));
        endcase
      end
      sender_gap();
      send_beat(b, 1'b0, none);
    end

    @(negedge clk) start <= 1'b0;
    wait_drained();
    // leave room for stray beats after the longest operation
    repeat (3 * DEPTH + 10) @(posedge clk);

    if (errors == 0) begin
      $display("tb_sorted_byte_list: PASS");
    end else begin
      $display("tb_sorted_byte_list: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
